// ===== rtl/itrd_pkg.sv =====
// Shared constants, digit coding and radix checks for the radix digit converter.
package itrd_pkg;

    // Default sizes of the value word and of the digit stack.
    localparam int VALUE_BITS_DEF = 31;
    localparam int MAX_DIGITS_DEF = 32;

    // One digit in any supported base fits in four bits.
    localparam int DIGIT_BITS = 4;

    // Quotient bits produced by the divider in each cycle.
    localparam int DIV_STEP_BITS = 8;

    // Radix limits and the reset value of the radix register.
    localparam int RADIX_MIN = 2;
    localparam int RADIX_DEC = 10;
    localparam int RADIX_HEX = 16;
    localparam logic [7:0] RADIX_RESET = 8'(RADIX_DEC);

    // ASCII codes of the first numeral and of the first letter.
    localparam logic [6:0] CHAR_ZERO = 7'h30;
    localparam logic [6:0] CHAR_A    = 7'h41;

    // True when the base is 2 to 10 or 16.
    function automatic logic radix_ok(input logic [7:0] r);
        return ((r >= 8'(RADIX_MIN)) && (r <= 8'(RADIX_DEC))) || (r == 8'(RADIX_HEX));
    endfunction

    // Digit value to ASCII: numerals first, then capital letters.
    function automatic logic [6:0] to_ascii(input logic [DIGIT_BITS-1:0] d);
        if (d < DIGIT_BITS'(RADIX_DEC)) begin
            return CHAR_ZERO + {3'b000, d};
        end else begin
            return CHAR_A + {3'b000, d - DIGIT_BITS'(RADIX_DEC)};
        end
    endfunction

endpackage

// ===== rtl/itrd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module itrd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/itrd_div.sv =====
// Iterative restoring divider by a small base, several quotient bits per cycle.
module itrd_div
    import itrd_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [WIDTH-1:0]      dividend,
    input  logic [4:0]            divisor,
    output logic                  done,
    output logic [WIDTH-1:0]      quotient,
    output logic [DIGIT_BITS-1:0] remainder
);

    localparam int ITERS = WIDTH / DIV_STEP_BITS;
    localparam int CNT_W = $clog2(ITERS + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [WIDTH-1:0]      shift_reg;
    logic [WIDTH-1:0]      shift_next;
    logic [DIGIT_BITS-1:0] rem_reg;
    logic [DIGIT_BITS-1:0] rem_next;

    // A handful of shift-and-subtract steps on the narrow partial remainder.
    always_comb begin
        logic [4:0] trial;
        logic [4:0] diff;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        for (int k = 0; k < DIV_STEP_BITS; k++) begin
            trial      = {rem_next, shift_next[WIDTH-1]};
            diff       = trial - divisor;
            shift_next = {shift_next[WIDTH-2:0], 1'b0};
            if (trial >= divisor) begin
                rem_next      = diff[DIGIT_BITS-1:0];
                shift_next[0] = 1'b1;
            end else begin
                rem_next = trial[DIGIT_BITS-1:0];
            end
        end
    end

    // Iteration counter and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(ITERS);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Dividend shifts out while quotient bits shift in.
    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end else if (cnt_reg != '0) begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = shift_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/integer_to_radix_digits.sv =====
// Top level: converts an integer to ASCII digits in a configured base.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+------------------------------------------
//  s_      | in        | s_tvalid / s_tready | s_tdata: value
//  m_      | out       | m_tvalid / m_tready | m_tdata: digit_char; m_tlast; m_tuser
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_data: radix
//
// Each digit costs one pass of the shared divider, at eight quotient bits a cycle, begun in
// ST_START and taken in ST_WAIT; once all digits are divided, each is popped through the
// registered stack read in ST_READ and ST_EMIT.
// Reset is synchronous and active low; the radix returns to ten. s_tready is low while a
// conversion runs, and a stalled m_ side holds the popping of the stack.
module integer_to_radix_digits
    import itrd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: value from bit 0, zero padded to whole bytes
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]  s_tdata,
    // m_tdata: digit_char in bits 6:0, bit 7 zero
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,
    output logic                             m_tlast,
    // m_tuser: bad_radix
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [7:0]                       cfg_data
);

    localparam int DIV_W  = ((VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS) * DIV_STEP_BITS;
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W = $clog2(MAX_DIGITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_READ,
        ST_EMIT,
        ST_ERROR
    } state_t;

    state_t                state_reg, state_next;
    logic [7:0]            radix_reg, radix_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      count_inc, count_dec;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  out_valid_reg, out_valid_next;
    logic [6:0]            out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_bad_reg, out_bad_next;
    logic                  out_free;

    logic                  div_start;
    logic                  div_done;
    logic [DIV_W-1:0]      div_quot;
    logic [DIGIT_BITS-1:0] div_rem;

    logic                  ram_we;
    logic [DIGIT_BITS-1:0] ram_rdata;

    assign count_inc = count_reg + CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);
    assign out_free  = !out_valid_reg || m_tready;
    assign div_start = (state_reg == ST_START);
    assign ram_we    = (state_reg == ST_WAIT) && div_done;

    // Shared divider by the configured base.
    itrd_div #(
        .WIDTH(DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (DIV_W'(value_reg)),
        .divisor  (radix_reg[4:0]),
        .done     (div_done),
        .quotient (div_quot),
        .remainder(div_rem)
    );

    // Digit stack: pushed at the fill count, popped one below it.
    itrd_ram #(
        .WIDTH(DIGIT_BITS),
        .DEPTH(MAX_DIGITS)
    ) u_stack (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(count_reg[ADDR_W-1:0]),
        .wdata(div_rem),
        .raddr(count_dec[ADDR_W-1:0]),
        .rdata(ram_rdata)
    );

    // Sequencer: divide until the quotient is zero or the stack is full, then pop; a bad base gives an error word.
    always_comb begin
        state_next     = state_reg;
        radix_next     = radix_reg;
        count_next     = count_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_bad_next   = out_bad_reg;

        if (cfg_valid) begin
            radix_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    value_next = s_tdata[VALUE_BITS-1:0];
                    count_next = '0;
                    state_next = radix_ok(radix_reg) ? ST_START : ST_ERROR;
                end
            end
            ST_START: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_done) begin
                    value_next = div_quot[VALUE_BITS-1:0];
                    count_next = count_inc;
                    if ((div_quot == '0) || (count_inc == CNT_W'(MAX_DIGITS))) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_START;
                    end
                end
            end
            ST_READ: begin
                if (out_free) begin
                    count_next = count_dec;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                out_valid_next = 1'b1;
                out_char_next  = to_ascii(ram_rdata);
                out_last_next  = (count_reg == '0);
                out_bad_next   = 1'b0;
                state_next     = (count_reg == '0) ? ST_IDLE : ST_READ;
            end
            ST_ERROR: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = '0;
                    out_last_next  = 1'b1;
                    out_bad_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counters and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            count_reg     <= '0;
            value_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            radix_reg     <= radix_next;
            count_reg     <= count_next;
            value_reg     <= value_next;
            out_valid_reg <= out_valid_next;
        end
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_char_reg};
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_bad_reg;

    // The pop loads the output register blindly, so it must be empty by then.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !out_valid_reg)
        else $error("output word overwritten by a popped digit");

    // The fill count never passes the stack depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond stack depth");

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_WAIT))
        else $error("divider result arrived outside the wait state");

    // An error word is a lone, marked word with a zero character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("malformed bad radix word");

endmodule

// ===== verif/tb_integer_to_radix_digits.sv =====
// Self-checking testbench for the integer to radix digit converter: random and directed words.
module tb_integer_to_radix_digits;
    import itrd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VBITS    = VALUE_BITS_DEF;
    localparam int DATA_W   = ((VBITS + 7) / 8) * 8;
    localparam int HOLD_OFF = 300;

    // One output word as the converter should present it.
    typedef struct packed {
        logic [6:0] digit_char;
        logic       last_digit;
        logic       bad_radix;
    } digit_word_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [7:0]        m_tdata;
    logic              m_tlast;
    logic              m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [7:0]        cfg_data  = '0;

    // Values waiting to be offered, and the digits still owed by the converter.
    logic [VBITS-1:0] value_feed_q[$];
    digit_word_t      digit_q[$];

    logic [7:0] radix_now      = RADIX_RESET;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         queued_total   = 0;
    int         accepted_total = 0;
    int         error_count    = 0;
    logic       hold_req       = 1'b0;
    logic       hold_active    = 1'b0;

    integer_to_radix_digits dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // A base is usable when it lies from two to ten, or is sixteen.
    function automatic logic base_is_legal(input logic [7:0] b);
        return (b >= 8'(RADIX_MIN) && b <= 8'(RADIX_DEC)) || b == 8'(RADIX_HEX);
    endfunction

    // Work out the digit words for one value under the current base.
    function automatic void predict_digits(input logic [VBITS-1:0] value);
        logic [3:0]       stack[$];
        logic [VBITS-1:0] rest;
        logic [VBITS-1:0] base;
        digit_word_t      w;
        if (!base_is_legal(radix_now)) begin
            w = '{digit_char: 7'd0, last_digit: 1'b1, bad_radix: 1'b1};
            digit_q.push_back(w);
            return;
        end
        base = VBITS'(radix_now);
        rest = value;
        if (rest == '0) begin
            stack.push_back(4'd0);
        end
        while (rest != '0 && stack.size() < MAX_DIGITS_DEF) begin
            stack.push_back(4'(rest % base));
            rest = rest / base;
        end
        // Most significant digit first, so the stack is read from the top.
        for (int i = stack.size() - 1; i >= 0; i--) begin
            w.digit_char = (stack[i] < 4'(RADIX_DEC)) ? CHAR_ZERO + 7'(stack[i])
                                                      : CHAR_A + 7'(stack[i] - 4'(RADIX_DEC));
            w.last_digit = (i == 0);
            w.bad_radix  = 1'b0;
            digit_q.push_back(w);
        end
    endfunction

    // Sender: a word once offered is held until it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_digits(s_tdata[VBITS-1:0]);
                accepted_total++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (value_feed_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= DATA_W'(value_feed_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each digit word against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (digit_q.size() == 0) begin
                    $display("%0t: unexpected digit word: expected none, %s %h last %b err %b",
                             $time, "got tdata", m_tdata, m_tlast, m_tuser);
                    error_count++;
                end else begin
                    digit_word_t want;
                    want = digit_q.pop_front();
                    if (m_tdata !== {1'b0, want.digit_char} || m_tlast !== want.last_digit ||
                        m_tuser !== want.bad_radix) begin
                        $display({"%0t: digit word mismatch: expected tdata %h last %b err %b,",
                                  " got tdata %h last %b err %b"},
                                 $time, {1'b0, want.digit_char}, want.last_digit,
                                 want.bad_radix, m_tdata, m_tlast, m_tuser);
                        error_count++;
                    end
                end
            end
            m_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
    initial begin
        wait (hold_req);
        @(posedge aclk);
        hold_active <= 1'b1;
        repeat (HOLD_OFF) @(posedge aclk);
        hold_active <= 1'b0;
    end

    task automatic queue_value(input logic [VBITS-1:0] v);
        value_feed_q.push_back(v);
        queued_total++;
    endtask

    // Wait until every word is taken and every digit has come out.
    task automatic drain();
        wait (accepted_total == queued_total);
        wait (digit_q.size() == 0);
        repeat (12) @(posedge aclk);
    endtask

    // Change the base; only called once the converter has gone quiet.
    task automatic write_radix(input logic [7:0] b);
        drain();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= b;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        radix_now = b;
    endtask

    function automatic logic [7:0] pick_radix();
        int sel;
        logic [7:0] b;
        sel = $urandom_range(99);
        if (sel < 15) begin
            // Bases that must be refused.
            do b = 8'($urandom_range(255)); while (base_is_legal(b));
        end else if (sel < 30) begin
            b = 8'(RADIX_HEX);
        end else begin
            b = 8'($urandom_range(RADIX_DEC, RADIX_MIN));
        end
        return b;
    endfunction

    function automatic logic [VBITS-1:0] pick_value();
        case ($urandom_range(3))
            0: return VBITS'($urandom_range(50));
            1: return VBITS'($urandom) & ((VBITS'(1) << $urandom_range(VBITS - 1, 1)) - 1'b1);
            default: return VBITS'($urandom);
        endcase
    endfunction

    function automatic void set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endfunction

    localparam logic [VBITS-1:0] VALUE_MAX = '1;
    localparam logic [7:0] REFUSED_BASES[6] = '{8'd0, 8'd1, 8'd11, 8'd15, 8'd17, 8'd255};

    // Stimulus: directed corners first, then random phases with varied bases and idling.
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Default base of ten straight after reset.
        queue_value('0);
        queue_value(VBITS'(1));
        queue_value(VBITS'(9));
        queue_value(VBITS'(10));
        queue_value(VALUE_MAX);
        queue_value(VBITS'(12345678));

        // Binary gives the longest digit strings.
        write_radix(8'(RADIX_MIN));
        queue_value(VALUE_MAX);
        queue_value('0);
        queue_value(VBITS'(1));
        queue_value(VBITS'(32'h2AAA_AAAA));

        // Hexadecimal exercises the letters.
        write_radix(8'(RADIX_HEX));
        queue_value(VALUE_MAX);
        queue_value(VBITS'(32'h00AB_CDEF));
        queue_value(VBITS'(32'h0FED_CBA9));
        queue_value('0);

        write_radix(8'd3);
        queue_value(VALUE_MAX);
        write_radix(8'd9);
        queue_value(VBITS'(32'h5555_5555));

        // Refused bases give one error word each.
        foreach (REFUSED_BASES[i]) begin
            write_radix(REFUSED_BASES[i]);
            queue_value(VBITS'($urandom));
        end

        // Random phases; phase four also holds the receiver off for a long stretch.
        for (int phase = 0; phase < 12; phase++) begin
            write_radix(pick_radix());
            set_idling(phase);
            if (phase == 4) begin
                hold_req = 1'b1;
            end
            for (int k = 0; k < 35; k++) begin
                if ($urandom_range(19) == 0) begin
                    queue_value(($urandom_range(1) == 0) ? '0 : VALUE_MAX);
                end else begin
                    queue_value(pick_value());
                end
            end
        end

        drain();
        repeat (100) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_integer_to_radix_digits passed");
        end else begin
            $display("tb_integer_to_radix_digits failed");
        end
        $finish;
    end

    // Watchdog for a converter that stops answering.
    initial begin
        #2000000;
        $display("tb_integer_to_radix_digits failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/itrd_pkg.sv
rtl/itrd_ram.sv
rtl/itrd_div.sv
rtl/integer_to_radix_digits.sv
verif/tb_integer_to_radix_digits.sv
